// ===== rtl/core/rpwdr_pkg.sv =====
// Package for the rotated pixel writer: codes, constants and the pixel packing function.
`default_nettype none

package rpwdr_pkg;

    // Default store geometry.
    localparam int DEFAULT_MAX_WIDTH  = 256;
    localparam int DEFAULT_MAX_HEIGHT = 256;

    // The effective panel size saturates at no more than this many pixels; the size registers reset to it.
    localparam int PANEL_LIMIT = 256;

    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 9;
    localparam int CHAN_W   = 8;
    localparam int INDEX_W  = 16;
    localparam int WORD_W   = 24;
    localparam int LOW_W    = 9;
    localparam int HIGH_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    // Watermark values of an empty dirty rectangle.
    localparam logic [LOW_W-1:0]  EMPTY_LOW  = 9'd511;
    localparam logic [HIGH_W-1:0] EMPTY_HIGH = 8'd0;

    // RGB565 packing masks.
    localparam logic [CHAN_W-1:0] RED_MASK       = 8'hF8;
    localparam logic [CHAN_W-1:0] GREEN_MID_MASK = 8'h1C;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MIN   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MAX   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MIN   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MAX   = 4'd7;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rotation_t;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_BGR888 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_RGB332 = 2'd3
    } pixel_format_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED      = 3'd0,
        ST_CLIPPED     = 3'd1,
        ST_OFF_PANEL   = 3'd2,
        ST_UNCHANGED   = 3'd3,
        ST_NOT_STORED  = 3'd4,
        ST_FLUSHED     = 3'd5,
        ST_NOTHING_DIRTY = 3'd6
    } status_t;

    localparam logic CMD_FLUSH = 1'b1;

    // Packs one color into the stored word for the given format.
    function automatic logic [WORD_W-1:0] pack_pixel(
        input pixel_format_t fmt,
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [CHAN_W-1:0] hi_byte;
        logic [CHAN_W-1:0] lo_byte;
        logic [WORD_W-1:0] word;
        hi_byte = (r & RED_MASK) | (g >> 5);
        lo_byte = ((g & GREEN_MID_MASK) << 3) | (b >> 3);
        case (fmt)
            FMT_RGB888: word = {b, g, r};
            FMT_BGR888: word = {r, g, b};
            FMT_RGB565: word = {8'd0, hi_byte, lo_byte};
            default:    word = '0;
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rotated_pixel_writer_dirty_rect.sv =====
// Rotated pixel writer with frame store and dirty-rectangle watermarks.
// Flow: a draw word passes S_CALC, S_INDEX, S_READ and S_DONE before the output register, a flush
// goes from S_IDLE to S_DONE. Items are taken one at a time: a new word is accepted only in S_IDLE,
// once the sequencer around the store read has finished the last item.
// Reset: configuration and watermarks return to defaults at once; then a clearing pass zeroes
// the frame store, one entry per cycle, over all min(MAX_WIDTH,256)*min(MAX_HEIGHT,256) entries
// (65536 by default), during which no input word is accepted. Configuration is always taken.
`default_nettype none

module rotated_pixel_writer_dirty_rect
    import rpwdr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: x_coord[11:0], y_coord[23:12], red[31:24], green[39:32], blue[47:40].
    input  wire logic [47:0]           s_tdata,
    // Fields from bit 0: cmd[0].
    input  wire logic [0:0]            s_tuser,

    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: store_index[15:0], pixel_word[39:16], dirty_col_low[48:40],
    // dirty_row_low[57:49], dirty_col_high[65:58], dirty_row_high[73:66], zero fill above.
    output logic [79:0]                m_tdata,
    // Fields from bit 0: status[2:0], region_valid[3].
    output logic [3:0]                 m_tuser,

    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The store only ever sees positions inside the saturated panel, so it is sized to that.
    localparam int STORE_W = (MAX_WIDTH  < PANEL_LIMIT) ? MAX_WIDTH  : PANEL_LIMIT;
    localparam int STORE_H = (MAX_HEIGHT < PANEL_LIMIT) ? MAX_HEIGHT : PANEL_LIMIT;
    localparam int DEPTH   = STORE_W * STORE_H;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CALC_W  = COORD_W + 2;

    localparam logic [SIZE_W-1:0] STORE_W_SZ = SIZE_W'(STORE_W);
    localparam logic [SIZE_W-1:0] STORE_H_SZ = SIZE_W'(STORE_H);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    // Per-item sequencer. Draws walk through S_CALC, S_INDEX and S_READ; a flush goes straight to S_DONE.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CALC  = 6'b000100,
        S_INDEX = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SIZE_W-1:0]      panel_width_reg, panel_height_reg;
    rotation_t              rotation_reg;
    pixel_format_t          pixel_format_reg;
    logic [COORD_W-1:0]     clip_x_min_reg, clip_x_max_reg, clip_y_min_reg, clip_y_max_reg;

    // Watermarks.
    logic [LOW_W-1:0]       low_col_reg, low_row_reg;
    logic [HIGH_W-1:0]      high_col_reg, high_row_reg;

    // Captured input word.
    logic                   cmd_reg;
    logic [COORD_W-1:0]     x_reg, y_reg;
    logic [CHAN_W-1:0]      red_reg, green_reg, blue_reg;

    // Intermediate results.
    logic                   clipped_reg;
    logic signed [CALC_W-1:0] col_reg, row_reg;
    logic                   off_panel_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [WORD_W-1:0]      word_reg;

    // Clearing pass counter.
    logic [ADDR_W-1:0]      clr_addr_reg;

    // Frame store and its registered read port.
    logic [WORD_W-1:0]      frame_store_mem [DEPTH];
    logic [WORD_W-1:0]      rd_data_reg;

    // Output register.
    logic                   m_tvalid_reg;
    status_t                out_status_reg;
    logic                   out_valid_rect_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic [WORD_W-1:0]      out_word_reg;
    logic [LOW_W-1:0]       out_dcl_reg, out_drl_reg;
    logic [HIGH_W-1:0]      out_dch_reg, out_drh_reg;

    // Effective panel size: the register saturated to what the store can hold.
    logic [SIZE_W-1:0]      eff_w, eff_h;
    assign eff_w = (panel_width_reg  > STORE_W_SZ) ? STORE_W_SZ : panel_width_reg;
    assign eff_h = (panel_height_reg > STORE_H_SZ) ? STORE_H_SZ : panel_height_reg;

    logic signed [CALC_W-1:0] w_s, h_s, x_s, y_s;
    assign w_s = $signed({{(CALC_W - SIZE_W){1'b0}}, eff_w});
    assign h_s = $signed({{(CALC_W - SIZE_W){1'b0}}, eff_h});
    assign x_s = $signed({{(CALC_W - COORD_W){x_reg[COORD_W-1]}}, x_reg});
    assign y_s = $signed({{(CALC_W - COORD_W){y_reg[COORD_W-1]}}, y_reg});

    // The clip window is tested on the logical coordinates.
    logic clip_out;
    assign clip_out = ($signed(x_reg) < $signed(clip_x_min_reg)) ||
                      ($signed(x_reg) > $signed(clip_x_max_reg)) ||
                      ($signed(y_reg) < $signed(clip_y_min_reg)) ||
                      ($signed(y_reg) > $signed(clip_y_max_reg));

    // Rotation into panel coordinates.
    logic signed [CALC_W-1:0] col_calc, row_calc;
    always_comb begin
        case (rotation_reg)
            ROT_90: begin
                col_calc = w_s - CALC_W'(1) - y_s;
                row_calc = x_s;
            end
            ROT_180: begin
                col_calc = w_s - CALC_W'(1) - x_s;
                row_calc = h_s - CALC_W'(1) - y_s;
            end
            ROT_270: begin
                col_calc = y_s;
                row_calc = h_s - CALC_W'(1) - x_s;
            end
            default: begin
                col_calc = x_s;
                row_calc = y_s;
            end
        endcase
    end

    // Panel bounds and the linear store index. Only the low eight bits of a position that
    // passed the bounds test are ever nonzero, so the product stays within the index width.
    logic                   off_calc;
    logic [HIGH_W-1:0]      col8, row8;
    logic [INDEX_W:0]       index_prod;
    assign off_calc   = (col_reg < 0) || (col_reg >= w_s) || (row_reg < 0) || (row_reg >= h_s);
    assign col8       = col_reg[HIGH_W-1:0];
    assign row8       = row_reg[HIGH_W-1:0];
    assign index_prod = (INDEX_W + 1)'(row8) * (INDEX_W + 1)'(eff_w) + (INDEX_W + 1)'(col8);

    // Final decision for the item in S_DONE.
    logic    out_free;
    logic    finish;
    status_t draw_status;
    logic    rect_valid;
    logic    do_write;
    logic    do_move;

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == S_DONE) && out_free;

    always_comb begin
        if (clipped_reg) begin
            draw_status = ST_CLIPPED;
        end else if (off_panel_reg) begin
            draw_status = ST_OFF_PANEL;
        end else begin
            case (pixel_format_reg)
                FMT_RGB565: begin
                    draw_status = (rd_data_reg == word_reg) ? ST_UNCHANGED : ST_STORED;
                end
                FMT_RGB332: draw_status = ST_NOT_STORED;
                default:    draw_status = ST_STORED;
            endcase
        end
    end

    assign rect_valid = ({1'b0, high_col_reg} >= low_col_reg) &&
                        ({1'b0, high_row_reg} >= low_row_reg);
    assign do_write   = finish && (cmd_reg != CMD_FLUSH) && (draw_status == ST_STORED);
    assign do_move    = finish && (cmd_reg != CMD_FLUSH) &&
                        ((draw_status == ST_STORED) || (draw_status == ST_NOT_STORED));

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == CMD_FLUSH) ? S_DONE : S_CALC;
                end
            end
            S_CALC:  state_next = S_INDEX;
            S_INDEX: state_next = S_READ;
            S_READ:  state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Control state, configuration and watermarks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
            panel_width_reg  <= SIZE_W'(PANEL_LIMIT);
            panel_height_reg <= SIZE_W'(PANEL_LIMIT);
            rotation_reg     <= ROT_0;
            pixel_format_reg <= FMT_RGB888;
            clip_x_min_reg   <= 12'h800;
            clip_x_max_reg   <= 12'h7FF;
            clip_y_min_reg   <= 12'h800;
            clip_y_max_reg   <= 12'h7FF;
            low_col_reg      <= EMPTY_LOW;
            low_row_reg      <= EMPTY_LOW;
            high_col_reg     <= EMPTY_HIGH;
            high_row_reg     <= EMPTY_HIGH;
        end else begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PANEL_WIDTH:  panel_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_PANEL_HEIGHT: panel_height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_ROTATION:     rotation_reg     <= rotation_t'(cfg_data[1:0]);
                    CFG_PIXEL_FORMAT: pixel_format_reg <= pixel_format_t'(cfg_data[1:0]);
                    CFG_CLIP_X_MIN:   clip_x_min_reg   <= cfg_data;
                    CFG_CLIP_X_MAX:   clip_x_max_reg   <= cfg_data;
                    CFG_CLIP_Y_MIN:   clip_y_min_reg   <= cfg_data;
                    CFG_CLIP_Y_MAX:   clip_y_max_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // A valid flush empties the rectangle; a draw with status stored or not stored grows it.
            if (finish && (cmd_reg == CMD_FLUSH) && rect_valid) begin
                low_col_reg  <= EMPTY_LOW;
                low_row_reg  <= EMPTY_LOW;
                high_col_reg <= EMPTY_HIGH;
                high_row_reg <= EMPTY_HIGH;
            end else if (do_move) begin
                if ({1'b0, col8} < low_col_reg) low_col_reg <= {1'b0, col8};
                if ({1'b0, row8} < low_row_reg) low_row_reg <= {1'b0, row8};
                if (col8 > high_col_reg) high_col_reg <= col8;
                if (row8 > high_row_reg) high_row_reg <= row8;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser[0];
            x_reg     <= s_tdata[11:0];
            y_reg     <= s_tdata[23:12];
            red_reg   <= s_tdata[31:24];
            green_reg <= s_tdata[39:32];
            blue_reg  <= s_tdata[47:40];
        end
        if (state_reg == S_CALC) begin
            clipped_reg <= clip_out;
            col_reg     <= col_calc;
            row_reg     <= row_calc;
        end
        if (state_reg == S_INDEX) begin
            off_panel_reg <= off_calc;
            index_reg     <= index_prod[INDEX_W-1:0];
            word_reg      <= pack_pixel(pixel_format_reg, red_reg, green_reg, blue_reg);
        end
        if (finish) begin
            if (cmd_reg == CMD_FLUSH) begin
                out_status_reg     <= rect_valid ? ST_FLUSHED : ST_NOTHING_DIRTY;
                out_valid_rect_reg <= rect_valid;
                out_index_reg      <= '0;
                out_word_reg       <= '0;
                out_dcl_reg        <= rect_valid ? low_col_reg  : '0;
                out_drl_reg        <= rect_valid ? low_row_reg  : '0;
                out_dch_reg        <= rect_valid ? high_col_reg : '0;
                out_drh_reg        <= rect_valid ? high_row_reg : '0;
            end else begin
                out_status_reg     <= draw_status;
                out_valid_rect_reg <= 1'b0;
                out_index_reg      <= (clipped_reg || off_panel_reg) ? '0 : index_reg;
                out_word_reg       <= (clipped_reg || off_panel_reg) ? '0 : word_reg;
                out_dcl_reg        <= '0;
                out_drl_reg        <= '0;
                out_dch_reg        <= '0;
                out_drh_reg        <= '0;
            end
        end
    end

    // Frame store: one write port shared by the clearing pass and draws, one registered read.
    // Items run one at a time, so a read never overlaps a pending write to the same entry.
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            frame_store_mem[clr_addr_reg] <= '0;
        end else if (do_write) begin
            frame_store_mem[index_reg[ADDR_W-1:0]] <= word_reg;
        end
        rd_data_reg <= frame_store_mem[index_reg[ADDR_W-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_valid_rect_reg, out_status_reg};
    assign m_tdata  = {6'd0, out_drh_reg, out_dch_reg, out_drl_reg, out_dcl_reg,
                       out_word_reg, out_index_reg};

endmodule

`default_nettype wire
